/* rtl/ntcts_pkg.sv */
// Package: shared types, threshold tables and band tables for the NTC temperature block.
package ntcts_pkg;

  localparam int AdcW    = 12;
  localparam int TempW   = 8;
  localparam int RomAw   = 7;
  localparam int BandAw  = 5;
  localparam int LenW    = 5;
  localparam int RomSize = 121;
  localparam int BandNum = 24;
  localparam int RiseJump = 6;
  // floor(x / 100) == (x * 5243) >> 19 for every 12-bit x
  localparam int RecipMul   = 5243;
  localparam int RecipShift = 19;
  localparam int RecipW     = 13;
  localparam int QuotW      = 6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BAND,
    ST_WALK,
    ST_FILT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load_item;
    logic band_setup;
    logic walk_step;
    logic commit;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_band;
    logic walk_done;
    logic out_free;
  } dp_sts_t;

  // ADC reading for 0..120 degrees, descending
  localparam logic [AdcW-1:0] ADC_ROM [RomSize] = '{
    12'd2432, 12'd2404,
    12'd2375, 12'd2346, 12'd2317,
    12'd2287, 12'd2257, 12'd2226,
    12'd2196, 12'd2165, 12'd2134, 12'd2102,
    12'd2071, 12'd2039, 12'd2007,
    12'd1976, 12'd1944, 12'd1912,
    12'd1880, 12'd1848, 12'd1816,
    12'd1784, 12'd1752, 12'd1721,
    12'd1689, 12'd1658, 12'd1627,
    12'd1597, 12'd1567, 12'd1537, 12'd1507,
    12'd1477, 12'd1448, 12'd1419,
    12'd1391, 12'd1362, 12'd1334, 12'd1307,
    12'd1279, 12'd1253, 12'd1226, 12'd1200,
    12'd1175, 12'd1149, 12'd1124,
    12'd1099, 12'd1075, 12'd1051, 12'd1028, 12'd1005,
    12'd982, 12'd960, 12'd938, 12'd917,
    12'd896, 12'd875, 12'd855, 12'd835, 12'd816,
    12'd797, 12'd779, 12'd760, 12'd743, 12'd725, 12'd708,
    12'd692, 12'd675, 12'd660, 12'd644, 12'd629, 12'd614, 12'd600,
    12'd585, 12'd572, 12'd558, 12'd545, 12'd532, 12'd520, 12'd507,
    12'd495, 12'd484, 12'd472, 12'd461, 12'd450, 12'd440, 12'd430, 12'd419, 12'd410,
    12'd400,
    12'd391, 12'd382, 12'd373, 12'd364, 12'd356, 12'd348, 12'd340, 12'd332, 12'd324,
    12'd317, 12'd309, 12'd302,
    12'd295, 12'd289, 12'd282, 12'd276, 12'd270, 12'd264, 12'd258, 12'd252, 12'd246,
    12'd241, 12'd235, 12'd230, 12'd225, 12'd220,
    12'd215, 12'd211, 12'd206, 12'd201,
    12'd197, 12'd193
  };

  localparam logic [RomAw-1:0] BAND_START [BandNum] = '{
    7'd0, 7'd2, 7'd5, 7'd8, 7'd12, 7'd15, 7'd18, 7'd21, 7'd24, 7'd27, 7'd31, 7'd34,
    7'd38, 7'd42, 7'd45, 7'd50, 7'd54, 7'd59, 7'd65, 7'd72, 7'd79, 7'd89, 7'd101, 7'd119
  };

  localparam logic [LenW-1:0] BAND_LEN [BandNum] = '{
    5'd2, 5'd3, 5'd3, 5'd4, 5'd3, 5'd3, 5'd3, 5'd3, 5'd3, 5'd4, 5'd3, 5'd4,
    5'd4, 5'd3, 5'd5, 5'd4, 5'd5, 5'd6, 5'd7, 5'd7, 5'd10, 5'd12, 5'd18, 5'd2
  };

  // threshold read; past the end reads as zero
  function automatic logic [AdcW-1:0] rom_read(input logic [RomAw-1:0] idx);
    logic [AdcW-1:0] val;
    val = '0;
    if (idx < RomAw'(RomSize)) begin
      val = ADC_ROM[idx];
    end
    return val;
  endfunction

  function automatic logic [RomAw-1:0] band_start(input logic [BandAw-1:0] band);
    logic [RomAw-1:0] val;
    val = '0;
    if (band < BandAw'(BandNum)) begin
      val = BAND_START[band];
    end
    return val;
  endfunction

  function automatic logic [LenW-1:0] band_len(input logic [BandAw-1:0] band);
    logic [LenW-1:0] val;
    val = LenW'(1);
    if (band < BandAw'(BandNum)) begin
      val = BAND_LEN[band];
    end
    return val;
  endfunction

endpackage

/* rtl/ntcts_if.sv */
// Interfaces: sample request channel, result channel and offset write channel.
interface ntcts_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [11:0] adc_value;

  modport source (output valid, output cmd, output adc_value, input ready);
  modport sink   (input valid, input cmd, input adc_value, output ready);
endinterface

interface ntcts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] temperature;
  logic [7:0] raw_temperature;
  logic       in_range;

  modport source (output valid, output temperature, output raw_temperature,
                  output in_range, input ready);
  modport sink   (input valid, input temperature, input raw_temperature,
                  input in_range, output ready);
endinterface

interface ntcts_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/ntc_adc_to_temperature_smoothed.sv */
// Top level: NTC ADC sample to temperature with slew-limited display value.
// Flow: band setup, a threshold walk (none when out of band), then the filter
//   commit, which waits for the previous result to be taken.
// Requests: a new request is taken only after the previous one has committed.
// Reset: held and shown temperatures, filter counters and offset clear to zero.
module ntc_adc_to_temperature_smoothed #(
  parameter int HOLD_COUNT = 3
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ntcts_in_if.sink      in_i,
  ntcts_out_if.source   out_o,
  ntcts_cfg_if.sink     cfg_i
);

  ntcts_pkg::ctrl_cmd_t ctrl_cmd;
  ntcts_pkg::dp_sts_t   dp_sts;

  // sequencing
  ntcts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .sts_i      (dp_sts),
    .cmd_o      (ctrl_cmd)
  );

  // datapath drives the channel ready from the load command
  ntcts_dp #(
    .HOLD_COUNT (HOLD_COUNT)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (ctrl_cmd),
    .sts_o  (dp_sts),
    .in_i   (in_i),
    .out_o  (out_o),
    .cfg_i  (cfg_i)
  );

endmodule

/* rtl/ntcts_ctrl.sv */
// Controller: sequences band setup, threshold walk and filter commit for one request.
module ntcts_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  ntcts_pkg::dp_sts_t    sts_i,
  output ntcts_pkg::ctrl_cmd_t  cmd_o
);

  ntcts_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ntcts_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ntcts_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = ntcts_pkg::ST_BAND;
      end
      ntcts_pkg::ST_BAND: begin
        state_d = sts_i.in_band ? ntcts_pkg::ST_WALK : ntcts_pkg::ST_FILT;
      end
      ntcts_pkg::ST_WALK: begin
        if (sts_i.walk_done) state_d = ntcts_pkg::ST_FILT;
      end
      ntcts_pkg::ST_FILT: begin
        if (sts_i.out_free) state_d = ntcts_pkg::ST_IDLE;
      end
      default: state_d = ntcts_pkg::ST_IDLE;
    endcase
  end

  // outputs; the load command doubles as the request ready
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ntcts_pkg::ST_IDLE: cmd_o.load_item  = in_valid_i;
      ntcts_pkg::ST_BAND: cmd_o.band_setup = 1'b1;
      ntcts_pkg::ST_WALK: cmd_o.walk_step  = 1'b1;
      ntcts_pkg::ST_FILT: cmd_o.commit     = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

/* rtl/ntcts_dp.sv */
// Datapath: band select, threshold walk, held lookup, slew filter and result register.
module ntcts_dp #(
  parameter int HOLD_COUNT = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ntcts_pkg::ctrl_cmd_t  cmd_i,
  output ntcts_pkg::dp_sts_t    sts_o,
  ntcts_in_if.sink              in_i,
  ntcts_out_if.source           out_o,
  ntcts_cfg_if.sink             cfg_i
);

  localparam int CntW  = $clog2(HOLD_COUNT + 1);
  localparam int AdcW  = ntcts_pkg::AdcW;
  localparam int TempW = ntcts_pkg::TempW;
  localparam int RomAw = ntcts_pkg::RomAw;
  localparam int LenW  = ntcts_pkg::LenW;
  localparam int ProdW = AdcW + ntcts_pkg::RecipW;

  // request capture
  logic            cmd_q;
  logic [AdcW-1:0] adc_q;

  // configuration
  logic [TempW-1:0] offset_q;

  // walk state
  logic [RomAw-1:0] start_q;
  logic [LenW-1:0]  len_q;
  logic [LenW-1:0]  idx_q;
  logic             hit_q;

  // lookup and filter state
  logic [TempW-1:0] held_q;
  logic [TempW-1:0] shown_q;
  logic             started_q;
  logic [CntW-1:0]  rise_q;
  logic [CntW-1:0]  fall_q;

  // result register
  logic             out_valid_q;
  logic [TempW-1:0] out_temp_q;
  logic [TempW-1:0] out_raw_q;
  logic             out_hit_q;

  // q = adc / 100 via reciprocal multiply
  logic [ProdW-1:0]                 prod;
  logic [ntcts_pkg::QuotW-1:0]      quot;
  logic [ntcts_pkg::BandAw-1:0]     band;
  logic                             in_band;

  assign prod    = ProdW'(adc_q) * ProdW'(ntcts_pkg::RecipMul);
  assign quot    = prod[ntcts_pkg::RecipShift +: ntcts_pkg::QuotW];
  assign in_band = (quot != '0) && (quot <= ntcts_pkg::QuotW'(ntcts_pkg::BandNum));
  assign band    = ntcts_pkg::BandAw'(ntcts_pkg::QuotW'(ntcts_pkg::BandNum) - quot);

  // one band entry and its successor per cycle
  logic [RomAw-1:0] rom_idx;
  logic [AdcW-1:0]  ent_a, ent_b;
  logic             last_idx, match, walk_done;

  assign rom_idx   = start_q + RomAw'(idx_q);
  assign ent_a     = ntcts_pkg::rom_read(rom_idx);
  assign ent_b     = ntcts_pkg::rom_read(rom_idx + RomAw'(1));
  assign last_idx  = (idx_q + LenW'(1)) >= len_q;
  assign match     = (ent_a == adc_q) || ((ent_a > adc_q) && (ent_b < adc_q));
  assign walk_done = last_idx || match;

  // slew filter on the held raw value
  logic [TempW-1:0] base;
  logic [TempW:0]   diff;
  logic             diff_neg, diff_pos, diff_small;
  logic [TempW-1:0] shown_nx;
  logic [CntW-1:0]  rise_nx, fall_nx;

  assign base       = started_q ? shown_q : held_q;
  assign diff       = {1'b0, held_q} - {1'b0, base};
  assign diff_neg   = diff[TempW];
  assign diff_pos   = !diff_neg && (diff != '0);
  assign diff_small = diff_pos && (diff < (TempW+1)'(ntcts_pkg::RiseJump));

  always_comb begin
    shown_nx = base;
    rise_nx  = rise_q;
    fall_nx  = fall_q;
    if (diff_small) begin
      fall_nx = '0;
      if (rise_q >= CntW'(HOLD_COUNT)) begin
        rise_nx  = '0;
        shown_nx = base + TempW'(1);
      end else begin
        rise_nx = rise_q + CntW'(1);
      end
    end else if (diff_pos) begin
      shown_nx = held_q;
    end else if (diff_neg) begin
      rise_nx = '0;
      if (fall_q >= CntW'(HOLD_COUNT)) begin
        fall_nx  = '0;
        shown_nx = base - TempW'(1);
      end else begin
        fall_nx = fall_q + CntW'(1);
      end
    end else begin
      rise_nx = '0;
      fall_nx = '0;
    end
  end

  // request payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      cmd_q <= in_i.cmd;
      adc_q <= in_i.adc_value;
    end
  end

  // offset register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else if (cfg_i.valid) begin
      offset_q <= cfg_i.data;
    end
  end

  // band setup and walk index
  always_ff @(posedge clk_i) begin
    if (cmd_i.band_setup) begin
      start_q <= ntcts_pkg::band_start(band);
      len_q   <= ntcts_pkg::band_len(band);
      idx_q   <= '0;
    end else if (cmd_i.walk_step && !walk_done) begin
      idx_q <= idx_q + LenW'(1);
    end
  end

  // held lookup and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q     <= 1'b0;
      held_q    <= '0;
      shown_q   <= '0;
      started_q <= 1'b0;
      rise_q    <= '0;
      fall_q    <= '0;
    end else begin
      if (cmd_i.band_setup) begin
        hit_q <= in_band;
      end
      if (cmd_i.walk_step && walk_done) begin
        held_q <= TempW'(rom_idx) + offset_q;
      end
      if (cmd_i.commit && !cmd_q) begin
        shown_q   <= shown_nx;
        started_q <= 1'b1;
        rise_q    <= rise_nx;
        fall_q    <= fall_nx;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_temp_q <= cmd_q ? held_q : shown_nx;
      out_raw_q  <= held_q;
      out_hit_q  <= hit_q;
    end
  end

  assign cfg_i.ready           = 1'b1;
  assign in_i.ready            = cmd_i.load_item;
  assign out_o.valid           = out_valid_q;
  assign out_o.temperature     = out_temp_q;
  assign out_o.raw_temperature = out_raw_q;
  assign out_o.in_range        = out_hit_q;

  assign sts_o.in_band   = in_band;
  assign sts_o.walk_done = walk_done;
  assign sts_o.out_free  = !out_valid_q || out_o.ready;

endmodule

/* dv/ntc_adc_to_temperature_smoothed_test.sv */
// Testbench: NTC lookup and slew filter checked against a cycle-free predictor.
module ntc_adc_to_temperature_smoothed_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HoldCount = 3;
  localparam int MaxCycles = 400000;
  localparam int PhaseNum = 6;
  localparam int PhaseItems = 115;
  localparam int DirNum = 24;

  // expected contents of one result
  typedef struct packed {
    logic [7:0] temperature;
    logic [7:0] raw_temperature;
    logic       in_range;
  } reading_t;

  // independent copy of the thermistor thresholds, 0..120 degrees
  localparam int unsigned THRESH [121] = '{
    2432, 2404, 2375, 2346, 2317, 2287, 2257, 2226, 2196, 2165, 2134, 2102,
    2071, 2039, 2007, 1976, 1944, 1912, 1880, 1848, 1816, 1784, 1752, 1721,
    1689, 1658, 1627, 1597, 1567, 1537, 1507, 1477, 1448, 1419, 1391, 1362,
    1334, 1307, 1279, 1253, 1226, 1200, 1175, 1149, 1124, 1099, 1075, 1051,
    1028, 1005, 982, 960, 938, 917, 896, 875, 855, 835, 816, 797, 779, 760,
    743, 725, 708, 692, 675, 660, 644, 629, 614, 600, 585, 572, 558, 545,
    532, 520, 507, 495, 484, 472, 461, 450, 440, 430, 419, 410, 400, 391,
    382, 373, 364, 356, 348, 340, 332, 324, 317, 309, 302, 295, 289, 282,
    276, 270, 264, 258, 252, 246, 241, 235, 230, 225, 220, 215, 211, 206,
    201, 197, 193
  };

  localparam int unsigned BAND_FIRST [24] = '{
    0, 2, 5, 8, 12, 15, 18, 21, 24, 27, 31, 34,
    38, 42, 45, 50, 54, 59, 65, 72, 79, 89, 101, 119
  };

  localparam int unsigned BAND_SPAN [24] = '{
    2, 3, 3, 4, 3, 3, 3, 3, 3, 4, 3, 4,
    4, 3, 5, 4, 5, 6, 7, 7, 10, 12, 18, 2
  };

  // directed requests: {cmd, adc_value}
  localparam logic [12:0] DIRECTED [DirNum] = '{
    {1'b0, 12'd0},    {1'b0, 12'd2404}, {1'b0, 12'd2404}, {1'b0, 12'd2404},
    {1'b0, 12'd2404}, {1'b0, 12'd2404}, {1'b0, 12'd2432}, {1'b0, 12'd100},
    {1'b1, 12'd99},   {1'b0, 12'd2499}, {1'b0, 12'd2500}, {1'b0, 12'd4095},
    {1'b0, 12'd1000}, {1'b1, 12'd400},  {1'b0, 12'd415},  {1'b1, 12'd2317},
    {1'b0, 12'd193},  {1'b0, 12'd192},  {1'b0, 12'd2433}, {1'b0, 12'd1950},
    {1'b0, 12'd2048}, {1'b0, 12'd1365}, {1'b1, 12'd2730}, {1'b0, 12'd201}
  };

  // predicts temperature readings and checks the block's results in order
  class temp_scoreboard;
    logic [7:0] offset;
    logic [7:0] held_raw;
    logic [7:0] shown;
    bit         started;
    int         rise_cnt;
    int         fall_cnt;
    int         errors;
    reading_t   pending_readings [$];

    function new();
      offset   = '0;
      held_raw = '0;
      shown    = '0;
      started  = 1'b0;
      rise_cnt = 0;
      fall_cnt = 0;
      errors   = 0;
    endfunction

    function void set_offset(logic [7:0] value);
      offset = value;
    endfunction

    function int pending();
      return pending_readings.size();
    endfunction

    // band search; updates the held raw value when the sample is in band
    function bit lookup_band(logic [11:0] adc);
      int unsigned q, band, first, span, pos, a, b;
      q = adc / 100;
      if (q < 1 || q > 24) return 1'b0;
      band  = 24 - q;
      first = BAND_FIRST[band];
      span  = BAND_SPAN[band];
      pos   = span - 1;
      for (int unsigned i = 0; i + 1 < span; i++) begin
        a = THRESH[first + i];
        b = THRESH[first + i + 1];
        if (a == adc || (a > adc && b < adc)) begin
          pos = i;
          break;
        end
      end
      held_raw = 8'(first + pos + offset);
      return 1'b1;
    endfunction

    // slew limiter on the shown value
    function void apply_slew();
      int diff;
      if (!started) begin
        shown   = held_raw;
        started = 1'b1;
      end
      diff = int'(held_raw) - int'(shown);
      if (diff > 0 && diff < 6) begin
        fall_cnt = 0;
        if (rise_cnt >= HoldCount) begin
          rise_cnt = 0;
          shown    = shown + 8'd1;
        end else begin
          rise_cnt++;
        end
      end else if (diff >= 6) begin
        shown = held_raw;
      end else if (diff < 0) begin
        rise_cnt = 0;
        if (fall_cnt >= HoldCount) begin
          fall_cnt = 0;
          shown    = shown - 8'd1;
        end else begin
          fall_cnt++;
        end
      end else begin
        rise_cnt = 0;
        fall_cnt = 0;
      end
    endfunction

    function void note_sample(logic cmd, logic [11:0] adc);
      reading_t r;
      r.in_range = lookup_band(adc);
      if (cmd == 1'b0) begin
        apply_slew();
        r.temperature = shown;
      end else begin
        r.temperature = held_raw;
      end
      r.raw_temperature = held_raw;
      pending_readings.push_back(r);
    endfunction

    function void check_reading(logic [7:0] temp, logic [7:0] raw, logic inr);
      reading_t r;
      if (pending_readings.size() == 0) begin
        $error("result with no request pending: temperature %0d", temp);
        errors++;
        return;
      end
      r = pending_readings.pop_front();
      if (temp !== r.temperature) begin
        $error("temperature: expected %0d, actual %0d", r.temperature, temp);
        errors++;
      end
      if (raw !== r.raw_temperature) begin
        $error("raw_temperature: expected %0d, actual %0d", r.raw_temperature, raw);
        errors++;
      end
      if (inr !== r.in_range) begin
        $error("in_range: expected %0d, actual %0d", r.in_range, inr);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   cycles;
  int   walk_temp;
  temp_scoreboard sb;

  ntcts_in_if  in_bus ();
  ntcts_out_if out_bus ();
  ntcts_cfg_if cfg_bus ();

  ntc_adc_to_temperature_smoothed #(
    .HOLD_COUNT(HoldCount)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus),
    .cfg_i (cfg_bus)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= MaxCycles) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side backpressure
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_bus.ready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // observe accepted requests, results and offset writes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) begin
        sb.check_reading(out_bus.temperature, out_bus.raw_temperature, out_bus.in_range);
      end
      if (in_bus.valid && in_bus.ready) begin
        sb.note_sample(in_bus.cmd, in_bus.adc_value);
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        sb.set_offset(cfg_bus.data);
      end
    end
  end

  // one sample request, with random gaps before it
  task automatic send_sample(logic cmd, logic [11:0] adc);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid     = 1'b1;
    in_bus.cmd       = cmd;
    in_bus.adc_value = adc;
    do @(posedge clk_i); while (!in_bus.ready);
  endtask

  // stop requesting and wait until every result has come back
  task automatic drain_results();
    @(negedge clk_i);
    in_bus.valid = 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
  endtask

  task automatic write_offset(logic [7:0] value);
    @(negedge clk_i);
    cfg_bus.valid = 1'b1;
    cfg_bus.data  = value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    @(negedge clk_i);
    cfg_bus.valid = 1'b0;
  endtask

  // mostly a slow temperature walk near thresholds, some noise and jumps
  task automatic send_random_sample();
    int   roll, adc;
    logic cmd;
    roll = $urandom_range(99);
    cmd  = ($urandom_range(9) == 0);
    if (roll < 12) begin
      adc = $urandom_range(4095);
    end else begin
      case ($urandom_range(9))
        4, 5, 6: walk_temp = walk_temp + 1;
        7, 8:    walk_temp = walk_temp - 1;
        9:       walk_temp = $urandom_range(120);
        default: walk_temp = walk_temp;
      endcase
      if (walk_temp < 0) walk_temp = 0;
      if (walk_temp > 120) walk_temp = 120;
      adc = int'(THRESH[walk_temp]) + $urandom_range(6) - 3;
    end
    send_sample(cmd, 12'(adc));
  endtask

  initial begin
    logic [7:0] off;
    sb               = new();
    cycles           = 0;
    walk_temp        = 60;
    tx_idle_pct      = 24;
    rx_idle_pct      = 81;
    rst_ni           = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.cmd       = 1'b0;
    in_bus.adc_value = '0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.data     = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int p = 0; p < PhaseNum; p++) begin
      // sender busy first, then receiver busy, then no idling
      case (p / 2)
        0: begin
          tx_idle_pct = 24;
          rx_idle_pct = 81;
        end
        1: begin
          tx_idle_pct = 81;
          rx_idle_pct = 24;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      case (p)
        0:       off = 8'd0;
        1:       off = 8'd255;
        3:       off = 8'd128;
        5:       off = 8'd1;
        default: off = 8'($urandom_range(255));
      endcase
      drain_results();
      write_offset(off);
      if (p == 0) begin
        for (int d = 0; d < DirNum; d++) begin
          send_sample(DIRECTED[d][12], DIRECTED[d][11:0]);
        end
      end
      for (int k = 0; k < PhaseItems; k++) begin
        // hold off once per phase until the pipe is empty
        if (k == 57) drain_results();
        send_random_sample();
      end
    end

    drain_results();
    repeat (30) @(posedge clk_i);
    if (sb.pending() > 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/ntcts_pkg.sv
rtl/ntcts_if.sv
rtl/ntcts_ctrl.sv
rtl/ntcts_dp.sv
rtl/ntc_adc_to_temperature_smoothed.sv
dv/ntc_adc_to_temperature_smoothed_test.sv
